FILE: sv/jkss_pkg.sv
`timescale 1ns / 1ps

package jkss_pkg;

   // Configuration port geometry and register indexes.
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 64;

   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_CHARS_LOW  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_CHARS_HIGH = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LENGTH     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_VALUE_MODE     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FALLBACK_VALUE = 3'd4;

   // Character codes used by the scanner.
   localparam logic [7:0] CHAR_QUOTE = 8'h22;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // Value mode codes.
   localparam logic MODE_INTEGER = 1'b0;
   localparam logic MODE_BOOLEAN = 1'b1;

   // One character moving from the input register into the scan logic.
   typedef struct packed {
      logic       valid;
      logic       last;
      logic [7:0] text_char;
   } step_type;

   // One result of a text.
   typedef struct packed {
      logic signed [31:0] scalar_value;
      logic               parsed_ok;
   } result_type;

   // Letters of the word true; positions past the end read as zero.
   function automatic logic [7:0] true_char(input logic [2:0] pos);
      logic [7:0] ch;
      case (pos)
         3'd0:    ch = 8'h74;
         3'd1:    ch = 8'h72;
         3'd2:    ch = 8'h75;
         3'd3:    ch = 8'h65;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // Letters of the word false; positions past the end read as zero.
   function automatic logic [7:0] false_char(input logic [2:0] pos);
      logic [7:0] ch;
      case (pos)
         3'd0:    ch = 8'h66;
         3'd1:    ch = 8'h61;
         3'd2:    ch = 8'h6C;
         3'd3:    ch = 8'h73;
         3'd4:    ch = 8'h65;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

FILE: sv/jkss_window.sv
`timescale 1ns / 1ps

module jkss_window #(
   parameter int unsigned MAX_KEY_CHARS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  jkss_pkg::step_type  step,
   input  logic [63:0]         key_chars_low,
   input  logic [63:0]         key_chars_high,
   input  logic [4:0]          key_length,
   output logic                key_match
);
   import jkss_pkg::*;

   localparam int unsigned DEPTH = MAX_KEY_CHARS + 2;
   localparam int unsigned LEN_W = $clog2(MAX_KEY_CHARS + 1);

   logic [7:0]           window_ff [DEPTH];
   logic [7:0]           window_in [DEPTH];
   logic [127:0]         key_all;
   logic [LEN_W-1:0]     len;
   logic [MAX_KEY_CHARS:0] match_by_len;

   assign key_all = {key_chars_high, key_chars_low};

   // Lengths beyond the supported maximum saturate.
   always_comb begin
      if (key_length > 5'(MAX_KEY_CHARS)) begin
         len = LEN_W'(MAX_KEY_CHARS);
      end else begin
         len = key_length[LEN_W-1:0];
      end
   end

   // Window as it stands once the current character has shifted in.
   always_comb begin
      window_in[0] = step.text_char;
      for (int k = 1; k < DEPTH; k++) begin
         window_in[k] = window_ff[k-1];
      end
   end

   // One quoted-key compare for every possible key length, all in parallel.
   for (genvar gl = 0; gl <= MAX_KEY_CHARS; gl++) begin : g_len
      logic [MAX_KEY_CHARS-1:0] char_eq;
      for (genvar gi = 0; gi < MAX_KEY_CHARS; gi++) begin : g_char
         if (gi < gl) begin : g_used
            assign char_eq[gi] = window_in[gl-gi] == key_all[8*gi +: 8];
         end else begin : g_unused
            assign char_eq[gi] = 1'b1;
         end
      end
      assign match_by_len[gl] = (window_in[0] == CHAR_QUOTE) &&
                                (window_in[gl+1] == CHAR_QUOTE) && (&char_eq);
   end

   assign key_match = match_by_len[len];

   // Shift line of recent characters; cleared after the last character of a text.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DEPTH; k++) begin
            window_ff[k] <= 8'h00;
         end
      end else if (step.valid) begin
         for (int k = 0; k < DEPTH; k++) begin
            window_ff[k] <= step.last ? 8'h00 : window_in[k];
         end
      end
   end

endmodule

FILE: sv/jkss_scan.sv
`timescale 1ns / 1ps

module jkss_scan (
   input  logic                 clock,
   input  logic                 reset,
   input  jkss_pkg::step_type   step,
   input  logic                 key_match,
   input  logic                 value_mode,
   input  logic [31:0]          fallback_value,
   output jkss_pkg::result_type result
);
   import jkss_pkg::*;

   typedef enum logic [2:0] {
      PH_SEARCH,
      PH_COLON,
      PH_SKIPWS,
      PH_DIGITS,
      PH_LITERAL,
      PH_DONE
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [31:0] magnitude_ff, magnitude_in;
   logic        negative_ff, negative_in;
   logic        saw_digit_ff, saw_digit_in;
   logic [2:0]  lit_pos_ff, lit_pos_in;
   logic [1:0]  lit_cand_ff, lit_cand_in;
   logic        held_ok_ff, held_ok_in;
   logic [31:0] held_value_ff, held_value_in;

   logic [7:0]  ch;
   logic        is_digit;
   logic        is_blank;
   logic [31:0] magnitude_step;
   logic [31:0] signed_magnitude;
   logic [2:0]  lit_pos_use;
   logic [1:0]  lit_cand_use;
   logic        true_hit;
   logic        false_hit;
   logic [1:0]  lit_cand_step;
   logic [2:0]  lit_pos_step;

   assign ch       = step.text_char;
   assign is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
   assign is_blank = (ch == CHAR_SPACE) || (ch == CHAR_TAB);

   // Decimal accumulate: times ten as two shifts and an add.
   assign magnitude_step = (magnitude_ff << 3) + (magnitude_ff << 1) +
                           {24'h000000, ch - CHAR_ZERO};

   // A literal that starts on this character begins at position zero with
   // both words still possible.
   assign lit_pos_use  = (phase_ff == PH_SKIPWS) ? 3'd0  : lit_pos_ff;
   assign lit_cand_use = (phase_ff == PH_SKIPWS) ? 2'b11 : lit_cand_ff;
   assign true_hit     = (lit_pos_use < 3'd4) && (ch == true_char(lit_pos_use));
   assign false_hit    = (lit_pos_use < 3'd5) && (ch == false_char(lit_pos_use));
   assign lit_cand_step = lit_cand_use & {false_hit, true_hit};
   assign lit_pos_step  = lit_pos_use + 3'd1;

   // Phase update for one character.
   always_comb begin
      phase_in      = phase_ff;
      magnitude_in  = magnitude_ff;
      negative_in   = negative_ff;
      saw_digit_in  = saw_digit_ff;
      lit_pos_in    = lit_pos_ff;
      lit_cand_in   = lit_cand_ff;
      held_ok_in    = held_ok_ff;
      held_value_in = held_value_ff;
      case (phase_ff)
         PH_SEARCH: begin
            if (key_match) begin
               phase_in = PH_COLON;
            end
         end
         PH_COLON: begin
            if (ch == CHAR_COLON) begin
               phase_in = PH_SKIPWS;
            end
         end
         PH_SKIPWS, PH_LITERAL: begin
            if (phase_ff == PH_SKIPWS && is_blank) begin
               phase_in = PH_SKIPWS;
            end else if (phase_ff == PH_SKIPWS && value_mode == MODE_INTEGER) begin
               // The first character only opens the number.
               if (ch == CHAR_MINUS) begin
                  negative_in = 1'b1;
                  phase_in    = PH_DIGITS;
               end else if (is_digit) begin
                  phase_in = PH_DIGITS;
               end else begin
                  phase_in      = PH_DONE;
                  held_ok_in    = 1'b0;
                  held_value_in = 32'h0;
               end
            end else begin
               lit_pos_in  = lit_pos_step;
               lit_cand_in = lit_cand_step;
               phase_in    = PH_LITERAL;
               if (lit_cand_step[0] && lit_pos_step == 3'd4) begin
                  phase_in      = PH_DONE;
                  held_ok_in    = 1'b1;
                  held_value_in = 32'h1;
               end else if (lit_cand_step[1] && lit_pos_step == 3'd5) begin
                  phase_in      = PH_DONE;
                  held_ok_in    = 1'b1;
                  held_value_in = 32'h0;
               end else if (lit_cand_step == 2'b00) begin
                  phase_in      = PH_DONE;
                  held_ok_in    = 1'b0;
                  held_value_in = 32'h0;
               end
            end
         end
         PH_DIGITS: begin
            if (is_digit) begin
               magnitude_in = magnitude_step;
               saw_digit_in = 1'b1;
            end else if (saw_digit_ff) begin
               phase_in      = PH_DONE;
               held_ok_in    = 1'b1;
               held_value_in = negative_ff ? (32'h0 - magnitude_ff) : magnitude_ff;
            end else begin
               phase_in      = PH_DONE;
               held_ok_in    = 1'b0;
               held_value_in = 32'h0;
            end
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
   end

   assign signed_magnitude = negative_in ? (32'h0 - magnitude_in) : magnitude_in;

   // Result of a text, from the state after its last character.
   always_comb begin
      if (phase_in == PH_DONE && held_ok_in) begin
         result.parsed_ok    = 1'b1;
         result.scalar_value = held_value_in;
      end else if (phase_in == PH_DIGITS && saw_digit_in) begin
         result.parsed_ok    = 1'b1;
         result.scalar_value = signed_magnitude;
      end else begin
         result.parsed_ok = 1'b0;
         if (value_mode == MODE_BOOLEAN) begin
            result.scalar_value = {31'h0, fallback_value != 32'h0};
         end else begin
            result.scalar_value = fallback_value;
         end
      end
   end

   // Scan state; everything rearms after the last character of a text.
   always_ff @(posedge clock) begin
      if (reset || (step.valid && step.last)) begin
         phase_ff      <= PH_SEARCH;
         magnitude_ff  <= 32'h0;
         negative_ff   <= 1'b0;
         saw_digit_ff  <= 1'b0;
         lit_pos_ff    <= 3'd0;
         lit_cand_ff   <= 2'b11;
         held_ok_ff    <= 1'b0;
         held_value_ff <= 32'h0;
      end else if (step.valid) begin
         phase_ff      <= phase_in;
         magnitude_ff  <= magnitude_in;
         negative_ff   <= negative_in;
         saw_digit_ff  <= saw_digit_in;
         lit_pos_ff    <= lit_pos_in;
         lit_cand_ff   <= lit_cand_in;
         held_ok_ff    <= held_ok_in;
         held_value_ff <= held_value_in;
      end
   end

endmodule

FILE: sv/json_key_scalar_scanner_unit.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake             Payload
// req_      in         req_tvalid/tready     tdata text_char, tlast end_of_text
// rsp_      out        rsp_tvalid/tready     tdata scalar_value, tuser parsed_ok
// csr_      in         csr_write_enable      csr_index, csr_write_data
//
// One character is taken every cycle; the per-character phase update in the
// scan core and the parallel window compare are both combinational.
// The last character of a text is staged in the input register, and its result
// is captured in the output register when that character moves on.
// Reset is synchronous and needs no clearing pass.
// A result that waits in the output register stalls only the last character
// of the following text; other characters keep flowing.

module json_key_scalar_scanner_unit #(
   parameter int unsigned MAX_KEY_CHARS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,      // [7:0] text_char
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [31:0]                       rsp_tdata,      // [31:0] scalar_value
   output logic                              rsp_tuser,      // [0] parsed_ok
   input  logic                              csr_write_enable,
   input  logic [jkss_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [jkss_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import jkss_pkg::*;

   logic [63:0] key_low_ff;
   logic [63:0] key_high_ff;
   logic [4:0]  key_length_ff;
   logic        value_mode_ff;
   logic [31:0] fallback_ff;

   logic        stage_valid_ff;
   logic        stage_last_ff;
   logic [7:0]  stage_char_ff;
   logic        advance;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_value_ff;
   logic        rsp_ok_ff;

   step_type    step;
   logic        key_match;
   result_type  result;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff    <= 64'h0;
         key_high_ff   <= 64'h0;
         key_length_ff <= 5'd1;
         value_mode_ff <= MODE_INTEGER;
         fallback_ff   <= 32'h0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_KEY_CHARS_LOW:  key_low_ff    <= csr_write_data;
            CSR_KEY_CHARS_HIGH: key_high_ff   <= csr_write_data;
            CSR_KEY_LENGTH:     key_length_ff <= csr_write_data[4:0];
            CSR_VALUE_MODE:     value_mode_ff <= csr_write_data[0];
            CSR_FALLBACK_VALUE: fallback_ff   <= csr_write_data[31:0];
            default:            key_low_ff    <= key_low_ff;
         endcase
      end
   end

   // A staged character moves on unless it ends a text and the result slot is busy.
   assign advance    = stage_valid_ff && (!stage_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !stage_valid_ff || advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_tready) begin
         stage_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         stage_char_ff <= req_tdata;
         stage_last_ff <= req_tlast;
      end
   end

   assign step.valid     = advance;
   assign step.last      = stage_last_ff;
   assign step.text_char = stage_char_ff;

   jkss_window #(
      .MAX_KEY_CHARS (MAX_KEY_CHARS)
   ) u_window (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .key_chars_low  (key_low_ff),
      .key_chars_high (key_high_ff),
      .key_length     (key_length_ff),
      .key_match      (key_match)
   );

   jkss_scan u_scan (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .key_match      (key_match),
      .value_mode     (value_mode_ff),
      .fallback_value (fallback_ff),
      .result         (result)
   );

   // Output register.
   always_comb begin
      if (advance && stage_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && stage_last_ff) begin
         rsp_value_ff <= result.scalar_value;
         rsp_ok_ff    <= result.parsed_ok;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_ok_ff;

endmodule

FILE: sv/jkss_checker.sv
`timescale 1ns / 1ps

module jkss_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tuser
);

   // After reset nothing is pending and a request can be taken.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("block not idle after reset");

   // The request side stalls only behind a result that is not being taken.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("request stalled without a blocked result");

   // A character that does not end a text never holds up the next one.
   a_mid_text_flow: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !req_tlast) |=> req_tready)
      else $error("stall after a mid-text request");

   // A result that is not taken stays unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled result changed");

endmodule

bind json_key_scalar_scanner_unit jkss_checker u_jkss_checker (.*);
